/* design/twma_pkg.sv */
// Shared types and constants for the time-weighted moving average block.
// No dependencies; used by the interfaces, controller, datapath and top level.
package twma_pkg;

  localparam int SAMPLE_W       = 16;
  localparam int INTERVAL_W     = 16;
  localparam int MEAN_W         = 16;
  localparam int WLEN_W         = 5;
  localparam int MAX_WINDOW_DEF = 16;

  localparam logic [WLEN_W-1:0] WLEN_RESET = WLEN_W'(10);

  localparam int APB_ADDR_W = 3;
  localparam int APB_DATA_W = 32;

  // register index is paddr[2]
  localparam logic REG_IDX_WINDOW_LEN = 1'b0;

  typedef struct packed {
    logic accept;
    logic rd_en;
    logic div_start;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic pipe_busy;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

/* design/twma_in_if.sv */
// Input channel: one sample word with its time interval.
// Depends on twma_pkg.
interface twma_in_if;
  import twma_pkg::*;

  logic                         valid;
  logic                         ready;
  logic signed [SAMPLE_W-1:0]   sample;
  logic        [INTERVAL_W-1:0] interval;

  modport source (output valid, sample, interval, input ready);
  modport sink   (input valid, sample, interval, output ready);

endinterface

/* design/twma_out_if.sv */
// Output channel: one mean word with its zero-time flag.
// Depends on twma_pkg.
interface twma_out_if;
  import twma_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [MEAN_W-1:0] mean;
  logic                     zero_time;

  modport source (output valid, mean, zero_time, input ready);
  modport sink   (input valid, mean, zero_time, output ready);

endinterface

/* design/time_weighted_moving_average_top.sv */
// Time-weighted sliding-window mean: top level with APB window_len register.
// Depends on twma_pkg, twma_in_if, twma_out_if, twma_ctrl and twma_dp.
//
// Usage:
//  in_i carries one word per item: a signed sample and its unsigned interval.
//  out_o returns one word per item: the interval-weighted mean of the last
//  window_len samples (truncated toward zero) and zero_time, set when the
//  interval sum of the window is zero and the previous mean is repeated
//  (the sample itself for the first item after reset).
//  window_len sits at APB byte address 0; 0 acts as 1, values above
//  MAX_WINDOW act as MAX_WINDOW. Write it only while the block is idle.
//  Each item reads one ring entry per cycle over the window, then runs a
//  restoring divider at one quotient bit per cycle (38 bits at the default
//  MAX_WINDOW of 16).
//  One item is in work at a time; in_i.ready is high only between items.
//  A finished word waits in the output register, so a stalled receiver
//  does not stop the next item from being accepted and computed; it then
//  holds until the output register frees.
//  Reset marks every ring entry invalid, clears the held mean and sets window_len to 10.
module time_weighted_moving_average_top #(
  parameter int MAX_WINDOW = twma_pkg::MAX_WINDOW_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  twma_in_if.sink                         in_i,
  twma_out_if.source                      out_o,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [twma_pkg::APB_ADDR_W-1:0] paddr,
  input  logic [twma_pkg::APB_DATA_W-1:0] pwdata,
  output logic [twma_pkg::APB_DATA_W-1:0] prdata,
  output logic                            pready
);
  import twma_pkg::*;

  logic [WLEN_W-1:0] wlen_q;
  cmd_t              cmd;
  sts_t              sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wlen_q <= WLEN_RESET;
    end else if (psel && penable && pwrite && (paddr[2] == REG_IDX_WINDOW_LEN)) begin
      wlen_q <= pwdata[WLEN_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_IDX_WINDOW_LEN) ? APB_DATA_W'(wlen_q) : '0;

  twma_ctrl #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .wlen_i     (wlen_q),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  twma_dp #(
    .MAX_WINDOW(MAX_WINDOW)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .sample_i    (in_i.sample),
    .interval_i  (in_i.interval),
    .out_ready_i (out_o.ready),
    .out_valid_o (out_o.valid),
    .mean_o      (out_o.mean),
    .zero_time_o (out_o.zero_time)
  );

endmodule

/* design/twma_ctrl.sv */
// Controller FSM: sequences ring write, window read, divide and output load.
// Depends on twma_pkg; drives twma_dp through cmd_t, watches sts_t.
module twma_ctrl #(
  parameter int MAX_WINDOW = twma_pkg::MAX_WINDOW_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [twma_pkg::WLEN_W-1:0] wlen_i,
  output twma_pkg::cmd_t              cmd_o,
  input  twma_pkg::sts_t              sts_i
);
  import twma_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_READ  = 5'b00010,
    ST_DRAIN = 5'b00100,
    ST_DIV   = 5'b01000,
    ST_OUT   = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [WLEN_W-1:0] cnt_q, cnt_d;
  logic [WLEN_W-1:0] len_eff;

  always_comb begin
    if (wlen_i == '0) begin
      len_eff = WLEN_W'(1);
    end else if (32'(wlen_i) > MAX_WINDOW) begin
      len_eff = WLEN_W'(MAX_WINDOW);
    end else begin
      len_eff = wlen_i;
    end
  end

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          cnt_d        = len_eff;
          state_d      = ST_READ;
        end
      end
      ST_READ: begin
        cmd_o.rd_en = 1'b1;
        cnt_d       = cnt_q - WLEN_W'(1);
        if (cnt_q == WLEN_W'(1)) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!sts_i.pipe_busy) begin
          cmd_o.div_start = 1'b1;
          state_d         = ST_DIV;
        end
      end
      ST_DIV: begin
        if (!sts_i.div_busy) begin
          state_d = ST_OUT;
        end
      end
      ST_OUT: begin
        if (sts_i.out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

/* design/twma_dp.sv */
// Datapath: sample/interval ring, multiply-accumulate over the window,
// restoring divider, held mean and output register. Depends on twma_pkg.
module twma_dp #(
  parameter int MAX_WINDOW = twma_pkg::MAX_WINDOW_DEF
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  twma_pkg::cmd_t                         cmd_i,
  output twma_pkg::sts_t                         sts_o,
  input  logic signed [twma_pkg::SAMPLE_W-1:0]   sample_i,
  input  logic        [twma_pkg::INTERVAL_W-1:0] interval_i,
  input  logic                                   out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [twma_pkg::MEAN_W-1:0]     mean_o,
  output logic                                   zero_time_o
);
  import twma_pkg::*;

  localparam int IDX_W   = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
  localparam int WIN_CAP = (MAX_WINDOW < 31) ? MAX_WINDOW : 31;
  localparam int GROW_W  = $clog2(WIN_CAP + 1);
  localparam int PROD_W  = SAMPLE_W + INTERVAL_W + 1;
  localparam int SUM_W   = PROD_W + GROW_W;
  localparam int TS_W    = INTERVAL_W + GROW_W;
  localparam int DCNT_W  = $clog2(SUM_W + 1);
  localparam int ENTRY_W = SAMPLE_W + INTERVAL_W;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_WINDOW - 1);

  // ring
  logic [ENTRY_W-1:0]    mem_q [MAX_WINDOW];
  logic [MAX_WINDOW-1:0] vld_q;
  logic [IDX_W-1:0]      wp_q, pos_q;

  // window accumulate pipeline
  logic                         rvld_q, pvld_q, rd_ok_q;
  logic [ENTRY_W-1:0]           rd_data_q;
  logic signed [PROD_W-1:0]     prod_q, prod_d;
  logic [INTERVAL_W-1:0]        tadd_q;
  logic signed [SUM_W-1:0]      ws_q;
  logic [TS_W-1:0]              ts_q;
  logic signed [SAMPLE_W-1:0]   sample_q;

  // divider
  logic              div_busy_q, neg_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [SUM_W-1:0]  dvd_q, dvd_d;
  logic [TS_W-1:0]   rem_q, rem_d;
  logic [TS_W:0]     rem_sh;
  logic [SUM_W-1:0]  ws_abs;

  // result
  logic signed [MEAN_W-1:0] held_q, res_mean, quot_lo;
  logic                     seen_q;
  logic                     out_valid_q, zero_q;
  logic signed [MEAN_W-1:0] mean_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      mem_q[wp_q] <= {sample_i, interval_i};
      sample_q    <= sample_i;
    end
    if (cmd_i.rd_en) begin
      rd_data_q <= mem_q[pos_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q   <= '0;
      wp_q    <= '0;
      pos_q   <= '0;
      rd_ok_q <= 1'b0;
      rvld_q  <= 1'b0;
      pvld_q  <= 1'b0;
    end else begin
      rvld_q <= cmd_i.rd_en;
      pvld_q <= rvld_q;
      if (cmd_i.accept) begin
        vld_q[wp_q] <= 1'b1;
        pos_q       <= wp_q;
        wp_q        <= (wp_q == LAST_IDX) ? '0 : wp_q + IDX_W'(1);
      end else if (cmd_i.rd_en) begin
        rd_ok_q <= vld_q[pos_q];
        pos_q   <= (pos_q == '0) ? LAST_IDX : pos_q - IDX_W'(1);
      end
    end
  end

  always_comb begin
    logic signed [PROD_W-1:0] s_ext, t_ext;
    s_ext  = PROD_W'(signed'(rd_data_q[ENTRY_W-1 -: SAMPLE_W]));
    t_ext  = signed'(PROD_W'(rd_data_q[INTERVAL_W-1:0]));
    prod_d = s_ext * t_ext;
  end

  always_ff @(posedge clk_i) begin
    if (rvld_q) begin
      prod_q <= rd_ok_q ? prod_d : '0;
      tadd_q <= rd_ok_q ? rd_data_q[INTERVAL_W-1:0] : '0;
    end
    if (cmd_i.accept) begin
      ws_q <= '0;
      ts_q <= '0;
    end else if (pvld_q) begin
      ws_q <= ws_q + SUM_W'(prod_q);
      ts_q <= ts_q + TS_W'(tadd_q);
    end
  end

  // restoring division, one quotient bit per cycle
  assign ws_abs = ws_q[SUM_W-1] ? SUM_W'(-ws_q) : SUM_W'(ws_q);
  assign rem_sh = {rem_q, dvd_q[SUM_W-1]};

  always_comb begin
    if (rem_sh >= {1'b0, ts_q}) begin
      rem_d = TS_W'(rem_sh - {1'b0, ts_q});
      dvd_d = {dvd_q[SUM_W-2:0], 1'b1};
    end else begin
      rem_d = rem_sh[TS_W-1:0];
      dvd_d = {dvd_q[SUM_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      dvd_q <= ws_abs;
      rem_q <= '0;
      neg_q <= ws_q[SUM_W-1];
    end else if (div_busy_q) begin
      dvd_q <= dvd_d;
      rem_q <= rem_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_busy_q <= 1'b0;
      dcnt_q     <= '0;
    end else if (cmd_i.div_start) begin
      div_busy_q <= 1'b1;
      dcnt_q     <= DCNT_W'(SUM_W);
    end else if (div_busy_q) begin
      dcnt_q <= dcnt_q - DCNT_W'(1);
      if (dcnt_q == DCNT_W'(1)) begin
        div_busy_q <= 1'b0;
      end
    end
  end

  assign quot_lo = neg_q ? MEAN_W'(-dvd_q) : MEAN_W'(dvd_q);

  always_comb begin
    if (ts_q == '0) begin
      res_mean = seen_q ? held_q : sample_q;
    end else begin
      res_mean = quot_lo;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q      <= '0;
      seen_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      held_q      <= res_mean;
      seen_q      <= 1'b1;
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      mean_q <= res_mean;
      zero_q <= (ts_q == '0);
    end
  end

  assign out_valid_o     = out_valid_q;
  assign mean_o          = mean_q;
  assign zero_time_o     = zero_q;
  assign sts_o.pipe_busy = rvld_q | pvld_q;
  assign sts_o.div_busy  = div_busy_q;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

endmodule
